/* rtl/core/hbcs_pkg.sv */
// ----------------------------------------------------------------------------
// hbcs_pkg: shared definitions of the header block splitter
// Constants of the frame format and the command record that the front end
// hands to the serializer.
// ----------------------------------------------------------------------------
package hbcs_pkg;

  localparam logic [23:0] MinFrameSize  = 24'd16384;
  localparam logic [23:0] PromisedLen   = 24'd4;
  localparam logic [7:0]  EndHeadersBit = 8'h04;
  localparam logic [7:0]  ContFrameType = 8'h09;
  localparam int unsigned CmdFifoDepth  = 4;

  localparam logic OpStart = 1'b0;
  localparam logic OpByte  = 1'b1;

  // One command: an optional frame header, an optional promised stream ID and
  // an optional data byte, serialized in that order.
  typedef struct packed {
    logic        hdr_en;
    logic [23:0] len;
    logic [7:0]  ftype;
    logic [7:0]  flags;
    logic [30:0] stream;
    logic        prom_en;
    logic [30:0] prom;
    logic        data_en;
    logic [7:0]  data;
    logic        fe;
    logic        se;
    logic        stray;
  } cmd_t;

endpackage

/* rtl/core/header_block_continuation_splitter_top.sv */
// ----------------------------------------------------------------------------
// header_block_continuation_splitter_top: HTTP/2 header block framer
// Splits an encoded header block into HEADERS or push promise frames plus
// CONTINUATION frames and serializes them one byte per result.
// ----------------------------------------------------------------------------
// A start transaction (operation 0) produces the 9-byte frame header of the
// first frame, followed by the 4-byte promised stream ID for push promises,
// so 9 or 13 results. Each block byte transaction (operation 1) produces one
// result, or ten when it opens a CONTINUATION frame, whose header goes out
// first. The end-headers flag is computed from the declared block length and
// the frame size register, which is clamped to at least 16384 and applies
// from the next frame header on. A byte with no open block, or past the
// declared length, is dropped and reported by a single result with status
// set. The front end takes one transaction per cycle while its command queue
// has room, and the serializer behind the queue delivers one result per
// cycle while results are popped, so a stream of block bytes flows at one byte
// per cycle; the serializer's one byte per cycle output is what sets the rate
// while headers are inserted. The result register lets a new result be built
// in the same cycle that the previous one is popped. Configuration writes are
// taken in any cycle and must only be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
module header_block_continuation_splitter_top #(
  parameter int unsigned CmdFifoDepth = hbcs_pkg::CmdFifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration channel: frame size register.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_max_frame_size_i,
  // Input queue side.
  input  logic        push,
  output logic        full,
  input  logic        operation_i,
  input  logic [7:0]  frame_type_i,
  input  logic [7:0]  base_flags_i,
  input  logic [31:0] stream_id_i,
  input  logic        has_promise_i,
  input  logic [31:0] promised_stream_id_i,
  input  logic [23:0] block_length_i,
  input  logic [7:0]  block_byte_i,
  // Result queue side.
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        sequence_end_o,
  output logic        run_last_o,
  output logic        status_o
);

  hbcs_pkg::cmd_t cmd_in;
  hbcs_pkg::cmd_t cmd_head;
  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_valid;
  logic           cmd_pop;

  // The register is a plain flop, so writes are never held off.
  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;

  // The front end classifies each transaction and updates the block and
  // frame counters at once, so the next transaction can follow directly.
  hbcs_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_max_frame_size_i (cfg_max_frame_size_i),
    .push_i               (push),
    .fifo_full_i          (cmd_full),
    .operation_i          (operation_i),
    .frame_type_i         (frame_type_i),
    .base_flags_i         (base_flags_i),
    .stream_id_i          (stream_id_i),
    .has_promise_i        (has_promise_i),
    .promised_stream_id_i (promised_stream_id_i),
    .block_length_i       (block_length_i),
    .block_byte_i         (block_byte_i),
    .cmd_push_o           (cmd_push),
    .cmd_o                (cmd_in)
  );

  // Commands wait here while the serializer is busy with inserted headers or its result is not popped.
  hbcs_cmd_fifo #(
    .Depth (CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_in),
    .full_o    (cmd_full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_head),
    .valid_o   (cmd_valid)
  );

  // The serializer emits the bytes of the head command, one per cycle while its results are popped.
  hbcs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (cmd_valid),
    .head_i         (cmd_head),
    .head_pop_o     (cmd_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_byte_o     (out_byte_o),
    .frame_end_o    (frame_end_o),
    .sequence_end_o (sequence_end_o),
    .run_last_o     (run_last_o),
    .status_o       (status_o)
  );

endmodule

/* rtl/core/hbcs_front.sv */
// ----------------------------------------------------------------------------
// hbcs_front: item classifier
// Holds the frame size register and the block and frame byte counters, and
// turns each accepted item into one serializer command.
// ----------------------------------------------------------------------------
module hbcs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [23:0]         cfg_max_frame_size_i,
  input  logic                push_i,
  input  logic                fifo_full_i,
  input  logic                operation_i,
  input  logic [7:0]          frame_type_i,
  input  logic [7:0]          base_flags_i,
  input  logic [31:0]         stream_id_i,
  input  logic                has_promise_i,
  input  logic [31:0]         promised_stream_id_i,
  input  logic [23:0]         block_length_i,
  input  logic [7:0]          block_byte_i,
  output logic                cmd_push_o,
  output hbcs_pkg::cmd_t      cmd_o
);

  logic [23:0] maxf_q, maxf_d;
  logic [23:0] maxf_push_q, maxf_push_d;
  logic [23:0] left_block_q, left_block_d;
  logic [23:0] left_frame_q, left_frame_d;
  logic [30:0] stream_q, stream_d;

  logic        accept;
  logic [23:0] cfg_eff;
  logic [23:0] room;
  logic        fits;
  logic        cfits;
  logic        need_hdr;
  logic [23:0] cont_len;
  logic [23:0] frame_cur;
  logic [23:0] frame_new;
  logic [23:0] block_new;

  assign accept     = push_i && !fifo_full_i;
  assign cmd_push_o = accept;

  // Sizes below the protocol minimum are clamped once, at write time.
  assign cfg_eff     = (cfg_max_frame_size_i < hbcs_pkg::MinFrameSize) ?
                       hbcs_pkg::MinFrameSize : cfg_max_frame_size_i;
  assign maxf_d      = cfg_valid_i ? cfg_eff : maxf_q;
  assign maxf_push_d = cfg_valid_i ? (cfg_eff - hbcs_pkg::PromisedLen) : maxf_push_q;

  assign room      = has_promise_i ? maxf_push_q : maxf_q;
  assign fits      = (block_length_i <= room);
  assign cfits     = (left_block_q <= maxf_q);
  assign need_hdr  = (left_frame_q == '0);
  assign cont_len  = cfits ? left_block_q : maxf_q;
  assign frame_cur = need_hdr ? cont_len : left_frame_q;
  assign frame_new = frame_cur - 24'd1;
  assign block_new = left_block_q - 24'd1;

  always_comb begin
    cmd_o        = '0;
    left_block_d = left_block_q;
    left_frame_d = left_frame_q;
    stream_d     = stream_q;
    if (operation_i == hbcs_pkg::OpStart) begin
      cmd_o.hdr_en  = 1'b1;
      cmd_o.len     = fits ? (block_length_i +
                              (has_promise_i ? hbcs_pkg::PromisedLen : 24'd0))
                           : maxf_q;
      cmd_o.ftype   = frame_type_i;
      cmd_o.flags   = (base_flags_i & ~hbcs_pkg::EndHeadersBit) |
                      (fits ? hbcs_pkg::EndHeadersBit : 8'h00);
      cmd_o.stream  = stream_id_i[30:0];
      cmd_o.prom_en = has_promise_i;
      cmd_o.prom    = promised_stream_id_i[30:0];
      cmd_o.fe      = (block_length_i == '0);
      cmd_o.se      = (block_length_i == '0);
      left_block_d  = block_length_i;
      left_frame_d  = fits ? block_length_i : room;
      stream_d      = stream_id_i[30:0];
    end else if (left_block_q == '0) begin
      cmd_o.data_en = 1'b1;
      cmd_o.stray   = 1'b1;
    end else begin
      cmd_o.hdr_en  = need_hdr;
      cmd_o.len     = cont_len;
      cmd_o.ftype   = hbcs_pkg::ContFrameType;
      cmd_o.flags   = cfits ? hbcs_pkg::EndHeadersBit : 8'h00;
      cmd_o.stream  = stream_q;
      cmd_o.data_en = 1'b1;
      cmd_o.data    = block_byte_i;
      cmd_o.fe      = (frame_new == '0);
      cmd_o.se      = (block_new == '0);
      left_block_d  = block_new;
      left_frame_d  = frame_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxf_q       <= hbcs_pkg::MinFrameSize;
      maxf_push_q  <= hbcs_pkg::MinFrameSize - hbcs_pkg::PromisedLen;
      left_block_q <= '0;
      left_frame_q <= '0;
      stream_q     <= '0;
    end else begin
      maxf_q      <= maxf_d;
      maxf_push_q <= maxf_push_d;
      if (accept) begin
        left_block_q <= left_block_d;
        left_frame_q <= left_frame_d;
        stream_q     <= stream_d;
      end
    end
  end

  // The open frame never holds more bytes than the block has left.
  a_frame_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_frame_q <= left_block_q)
    else $error("frame counter exceeds block counter");

  // A refused item must not move the counters.
  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && fifo_full_i) |=> $stable(left_block_q) && $stable(left_frame_q))
    else $error("counters changed on a refused item");

endmodule

/* rtl/core/hbcs_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// hbcs_cmd_fifo: command queue
// Short register queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module hbcs_cmd_fifo #(
  parameter int unsigned Depth = hbcs_pkg::CmdFifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  hbcs_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output hbcs_pkg::cmd_t rd_data_o,
  output logic           valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hbcs_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  assign wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
  assign rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_d;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_d;
      end
    end
  end

endmodule

/* rtl/core/hbcs_back.sv */
// ----------------------------------------------------------------------------
// hbcs_back: byte serializer
// Walks each queued command byte by byte into the output register.
// ----------------------------------------------------------------------------
module hbcs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  hbcs_pkg::cmd_t head_i,
  output logic           head_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [7:0]     out_byte_o,
  output logic           frame_end_o,
  output logic           sequence_end_o,
  output logic           run_last_o,
  output logic           status_o
);

  // Byte positions within one command.
  localparam logic [3:0] PosLen0   = 4'd0;
  localparam logic [3:0] PosLen1   = 4'd1;
  localparam logic [3:0] PosLen2   = 4'd2;
  localparam logic [3:0] PosType   = 4'd3;
  localparam logic [3:0] PosFlags  = 4'd4;
  localparam logic [3:0] PosStr0   = 4'd5;
  localparam logic [3:0] PosStr1   = 4'd6;
  localparam logic [3:0] PosStr2   = 4'd7;
  localparam logic [3:0] PosStr3   = 4'd8;
  localparam logic [3:0] PosProm0  = 4'd9;
  localparam logic [3:0] PosProm1  = 4'd10;
  localparam logic [3:0] PosProm2  = 4'd11;
  localparam logic [3:0] PosProm3  = 4'd12;
  localparam logic [3:0] PosData   = 4'd13;

  logic [3:0] pos_q, pos_d;
  logic       started_q, started_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] obyte_q;
  logic       ofe_q, ose_q, olast_q, ostat_q;

  logic [3:0] cur_pos;
  logic [7:0] cur_byte;
  logic       last;
  logic       emit;

  assign cur_pos = started_q ? pos_q : (head_i.hdr_en ? PosLen0 : PosData);
  assign emit    = head_valid_i && (!ovalid_q || pop_i);
  assign last    = ((cur_pos == PosStr3) && !head_i.prom_en && !head_i.data_en) ||
                   (cur_pos == PosProm3) || (cur_pos == PosData);
  assign pos_d   = (cur_pos == PosStr3) ? (head_i.prom_en ? PosProm0 : PosData) :
                                          cur_pos + 4'd1;
  assign started_d  = emit ? !last : started_q;
  assign head_pop_o = emit && last;
  assign ovalid_d   = emit ? 1'b1 : (pop_i ? 1'b0 : ovalid_q);

  always_comb begin
    case (cur_pos)
      PosLen0:  cur_byte = head_i.len[23:16];
      PosLen1:  cur_byte = head_i.len[15:8];
      PosLen2:  cur_byte = head_i.len[7:0];
      PosType:  cur_byte = head_i.ftype;
      PosFlags: cur_byte = head_i.flags;
      PosStr0:  cur_byte = {1'b0, head_i.stream[30:24]};
      PosStr1:  cur_byte = head_i.stream[23:16];
      PosStr2:  cur_byte = head_i.stream[15:8];
      PosStr3:  cur_byte = head_i.stream[7:0];
      PosProm0: cur_byte = {1'b0, head_i.prom[30:24]};
      PosProm1: cur_byte = head_i.prom[23:16];
      PosProm2: cur_byte = head_i.prom[15:8];
      PosProm3: cur_byte = head_i.prom[7:0];
      PosData:  cur_byte = head_i.data;
      default:  cur_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= PosLen0;
      started_q <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      started_q <= started_d;
      ovalid_q  <= ovalid_d;
      if (emit) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      obyte_q <= cur_byte;
      ofe_q   <= last && head_i.fe;
      ose_q   <= last && head_i.se;
      olast_q <= last;
      ostat_q <= head_i.stray;
    end
  end

  assign empty_o        = !ovalid_q;
  assign out_byte_o     = obyte_q;
  assign frame_end_o    = ofe_q;
  assign sequence_end_o = ose_q;
  assign run_last_o     = olast_q;
  assign status_o       = ostat_q;

  // A command stays at the queue head until its last byte is out.
  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> head_valid_i)
    else $error("command left the queue while being serialized");

  // A dropped byte gives exactly one result that closes its transaction.
  a_stray_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostat_q) |-> (olast_q && !ofe_q && !ose_q))
    else $error("malformed dropped byte result");

  // Frame and sequence ends only fall on the last byte of a command.
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && (ofe_q || ose_q)) |-> olast_q)
    else $error("frame end away from command end");

endmodule
